// ===== hdl/sfeu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfeu_pkg: shared types and constants
// Node count, field widths, cell chain and broadcast structs, control states.
// ----------------------------------------------------------------------------
package sfeu_pkg;

  localparam int Nodes = 16;
  localparam int NodeW = 4;
  localparam int SizeW = 5;

  localparam logic [SizeW-1:0] NodeCountRst = SizeW'(9);

  localparam logic OpClear = 1'b0;
  localparam logic OpEdge  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  // values gathered along the row of cells
  typedef struct packed {
    logic [NodeW-1:0] la;
    logic [NodeW-1:0] lb;
    logic [SizeW-1:0] sa;
    logic [SizeW-1:0] sb;
  } chain_t;

  // values sent to every cell at once
  typedef struct packed {
    logic [NodeW-1:0] look_a;
    logic [NodeW-1:0] look_b;
    logic [NodeW-1:0] sel_la;
    logic [NodeW-1:0] sel_lb;
    logic             clear;
    logic             merge;
    logic [SizeW-1:0] sum;
  } bcast_t;

  typedef struct packed {
    logic accept;
    logic merge;
  } ctrl_t;

endpackage

// ===== hdl/sfeu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfeu_cell: one node cell
// Holds one node's group label and the size of the group with its own label;
// ORs its label and size into the values passed along the chain when its index is selected.
// ----------------------------------------------------------------------------
module sfeu_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [sfeu_pkg::NodeW-1:0] index_i,
  input  sfeu_pkg::bcast_t          bcast_i,
  input  sfeu_pkg::chain_t          chain_i,
  output sfeu_pkg::chain_t          chain_o
);

  logic [sfeu_pkg::NodeW-1:0] label_q, label_d;
  logic [sfeu_pkg::SizeW-1:0] size_q, size_d;

  always_comb begin
    chain_o = chain_i;
    if (index_i == bcast_i.look_a) chain_o.la = chain_i.la | label_q;
    if (index_i == bcast_i.look_b) chain_o.lb = chain_i.lb | label_q;
    if (index_i == bcast_i.sel_la) chain_o.sa = chain_i.sa | size_q;
    if (index_i == bcast_i.sel_lb) chain_o.sb = chain_i.sb | size_q;
  end

  always_comb begin
    label_d = label_q;
    size_d  = size_q;
    priority if (bcast_i.clear) begin
      label_d = index_i;
      size_d  = sfeu_pkg::SizeW'(1);
    end else if (bcast_i.merge) begin
      if (label_q == bcast_i.sel_lb) label_d = bcast_i.sel_la;
      if (index_i == bcast_i.sel_la) size_d = bcast_i.sum;
      else if (index_i == bcast_i.sel_lb) size_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q <= index_i;
      size_q  <= sfeu_pkg::SizeW'(1);
    end else begin
      label_q <= label_d;
      size_q  <= size_d;
    end
  end

endmodule

// ===== hdl/sfeu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfeu_ctrl: item sequencer
// Takes an item in ST_IDLE, then does the relabel and size update in ST_MERGE.
// ----------------------------------------------------------------------------
module sfeu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output sfeu_pkg::ctrl_t   ctrl_o
);

  sfeu_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfeu_pkg::ST_IDLE:  if (start) state_d = sfeu_pkg::ST_MERGE;
      sfeu_pkg::ST_MERGE: state_d = sfeu_pkg::ST_IDLE;
      default:            state_d = sfeu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b0;
    ctrl_o.accept = 1'b0;
    ctrl_o.merge  = 1'b0;
    unique case (state_q)
      sfeu_pkg::ST_IDLE:  ctrl_o.accept = start;
      sfeu_pkg::ST_MERGE: begin
        busy         = 1'b1;
        ctrl_o.merge = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfeu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/spanning_forest_edge_union.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spanning_forest_edge_union: edge union over a row of node cells
// The item and its looked-up labels are registered at accept; the relabel/size
// update in ST_MERGE registers the result strobe; no item is taken while busy.
// Reset puts every node in its own group and node_count at 9.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module spanning_forest_edge_union (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       op_i,
  input  logic [sfeu_pkg::NodeW-1:0] first_node_i,
  input  logic [sfeu_pkg::NodeW-1:0] second_node_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sfeu_pkg::SizeW-1:0] cfg_data_i,
  output logic                       result_valid_o,
  output logic                       joined_o,
  output logic [sfeu_pkg::NodeW-1:0] group_label_o,
  output logic [sfeu_pkg::SizeW-1:0] group_size_o,
  output logic                       complete_o
);

  sfeu_pkg::ctrl_t  ctrl;
  sfeu_pkg::bcast_t bcast;
  sfeu_pkg::chain_t chain [sfeu_pkg::Nodes+1];

  logic [sfeu_pkg::SizeW-1:0] node_count_q;
  logic                       op_q;
  logic [sfeu_pkg::NodeW-1:0] a_q, b_q, la_q, lb_q;

  logic                       a_ok, b_ok, join_w;
  logic [sfeu_pkg::SizeW:0]   sum_w;
  logic [sfeu_pkg::SizeW-1:0] size_w;
  logic [sfeu_pkg::NodeW-1:0] label_w;

  logic                       valid_q;
  logic                       joined_q, complete_q;
  logic [sfeu_pkg::NodeW-1:0] label_q;
  logic [sfeu_pkg::SizeW-1:0] size_q;

  sfeu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= sfeu_pkg::NodeCountRst;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  assign a_ok = 32'(a_q) < sfeu_pkg::Nodes;
  assign b_ok = 32'(b_q) < sfeu_pkg::Nodes;

  assign sum_w  = {1'b0, chain[sfeu_pkg::Nodes].sa} + {1'b0, chain[sfeu_pkg::Nodes].sb};
  assign join_w = (op_q == sfeu_pkg::OpEdge) && a_ok && b_ok && (la_q != lb_q);

  always_comb begin
    bcast.look_a = first_node_i;
    bcast.look_b = second_node_i;
    bcast.sel_la = la_q;
    bcast.sel_lb = lb_q;
    bcast.clear  = ctrl.merge && (op_q == sfeu_pkg::OpClear);
    bcast.merge  = ctrl.merge && join_w;
    bcast.sum    = sum_w[sfeu_pkg::SizeW-1:0];
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < sfeu_pkg::Nodes; i++) begin : g_cell
    sfeu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .index_i (sfeu_pkg::NodeW'(i)),
      .bcast_i (bcast),
      .chain_i (chain[i]),
      .chain_o (chain[i+1])
    );
  end

  // item beat and looked-up labels
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      op_q <= op_i;
      a_q  <= first_node_i;
      b_q  <= second_node_i;
      la_q <= chain[sfeu_pkg::Nodes].la;
      lb_q <= chain[sfeu_pkg::Nodes].lb;
    end
  end

  always_comb begin
    if ((op_q == sfeu_pkg::OpClear) || !a_ok) begin
      label_w = a_q;
      size_w  = sfeu_pkg::SizeW'(1);
    end else begin
      label_w = la_q;
      size_w  = join_w ? sum_w[sfeu_pkg::SizeW-1:0] : chain[sfeu_pkg::Nodes].sa;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl.merge;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.merge) begin
      joined_q   <= join_w;
      label_q    <= label_w;
      size_q     <= size_w;
      complete_q <= size_w >= node_count_q;
    end
  end

  assign result_valid_o = valid_q;
  assign joined_o       = joined_q;
  assign group_label_o  = label_q;
  assign group_size_o   = size_q;
  assign complete_o     = complete_q;

endmodule
